// ----- sv/apt_pkg.sv -----
// Shared types and constants of the affine point transform unit.
// No dependencies; imported by the lane, merge and top-level modules.
package apt_pkg;

  localparam int ENTRY_COUNT = 12;
  localparam int COORD_W     = 32;
  localparam int INDEX_W     = 4;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_XFORM = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic adv_mul;
    logic adv_sum;
    logic adv_out;
  } pipe_ctl_t;

endpackage

// ----- sv/apt_lane.sv -----
// One row lane: three entry-by-coordinate products, rounding and translation add.
// Depends on apt_pkg.
module apt_lane
  import apt_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int ACC_W     = 50
) (
  input  logic                    clk,
  input  pipe_ctl_t               ctl,
  input  coord_t                  coef_x,
  input  coord_t                  coef_y,
  input  coord_t                  coef_z,
  input  coord_t                  trans,
  input  coord_t                  point_x,
  input  coord_t                  point_y,
  input  coord_t                  point_z,
  output logic signed [ACC_W-1:0] acc
);

  localparam int PROD_W = 2 * COORD_W;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (FRAC_BITS - 1);

  logic signed [PROD_W-1:0] prod_x;
  logic signed [PROD_W-1:0] prod_y;
  logic signed [PROD_W-1:0] prod_z;
  coord_t                   trans_q;

  logic signed [PROD_W-1:0] rnd_x;
  logic signed [PROD_W-1:0] rnd_y;
  logic signed [PROD_W-1:0] rnd_z;
  logic signed [ACC_W-1:0]  acc_next;

  always_ff @(posedge clk) begin
    if (ctl.adv_mul) begin
      prod_x  <= PROD_W'(coef_x) * PROD_W'(point_x);
      prod_y  <= PROD_W'(coef_y) * PROD_W'(point_y);
      prod_z  <= PROD_W'(coef_z) * PROD_W'(point_z);
      trans_q <= trans;
    end
  end

  always_comb begin
    rnd_x    = (prod_x + HALF) >>> FRAC_BITS;
    rnd_y    = (prod_y + HALF) >>> FRAC_BITS;
    rnd_z    = (prod_z + HALF) >>> FRAC_BITS;
    acc_next = ACC_W'(rnd_x) + ACC_W'(rnd_y) + ACC_W'(rnd_z) + ACC_W'(trans_q);
  end

  always_ff @(posedge clk) begin
    if (ctl.adv_sum) begin
      acc <= acc_next;
    end
  end

endmodule

// ----- sv/apt_merge.sv -----
// Merge stage: clamps the three lane sums to 32 bits and combines the clamp flags.
// Depends on apt_pkg.
module apt_merge
  import apt_pkg::*;
#(
  parameter int ACC_W = 50
) (
  input  logic                    clk,
  input  pipe_ctl_t               ctl,
  input  logic signed [ACC_W-1:0] acc_x,
  input  logic signed [ACC_W-1:0] acc_y,
  input  logic signed [ACC_W-1:0] acc_z,
  output coord_t                  out_x,
  output coord_t                  out_y,
  output coord_t                  out_z,
  output logic                    saturated
);

  localparam logic signed [ACC_W-1:0] MAX_V = ACC_W'(coord_t'({1'b0, {(COORD_W-1){1'b1}}}));
  localparam logic signed [ACC_W-1:0] MIN_V = ACC_W'(coord_t'({1'b1, {(COORD_W-1){1'b0}}}));

  logic   hi_x, lo_x, hi_y, lo_y, hi_z, lo_z;
  coord_t cx, cy, cz;

  always_comb begin
    hi_x = acc_x > MAX_V;
    lo_x = acc_x < MIN_V;
    hi_y = acc_y > MAX_V;
    lo_y = acc_y < MIN_V;
    hi_z = acc_z > MAX_V;
    lo_z = acc_z < MIN_V;
    cx = hi_x ? COORD_W'(MAX_V) : (lo_x ? COORD_W'(MIN_V) : COORD_W'(acc_x));
    cy = hi_y ? COORD_W'(MAX_V) : (lo_y ? COORD_W'(MIN_V) : COORD_W'(acc_y));
    cz = hi_z ? COORD_W'(MAX_V) : (lo_z ? COORD_W'(MIN_V) : COORD_W'(acc_z));
  end

  always_ff @(posedge clk) begin
    if (ctl.adv_out) begin
      out_x     <= cx;
      out_y     <= cy;
      out_z     <= cz;
      saturated <= hi_x | lo_x | hi_y | lo_y | hi_z | lo_z;
    end
  end

endmodule

// ----- sv/affine_point_transform_unit.sv -----
// Top level of the affine point transform unit: matrix registers, pipeline control,
// three row lanes and the merge stage. Depends on apt_pkg, apt_lane and apt_merge.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------------------------------
//   in      | in_valid / in_stall | opcode, entry_index, entry_value, point_x/y/z
//   out     | out_valid/out_stall | out_x, out_y, out_z, saturated
//
// One request per clock while in_stall is low. The edge that takes a transform
// registers its products, which are rounded and summed into the sum register, then
// clamped into the output register. A load updates the matrix at its edge and gives
// no result. Reset sets the matrix to identity and empties the pipeline. A stalled
// output holds; in_stall rises only when every stage is full and out_stall is high.
module affine_point_transform_unit
  import apt_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic [INDEX_W-1:0] entry_index,
  input  coord_t             entry_value,
  input  coord_t             point_x,
  input  coord_t             point_y,
  input  coord_t             point_z,
  output logic               out_valid,
  input  logic               out_stall,
  output coord_t             out_x,
  output coord_t             out_y,
  output coord_t             out_z,
  output logic               saturated
);

  localparam int ACC_W = 2 * COORD_W + 2 - FRAC_BITS;
  localparam coord_t ONE = COORD_W'(1) <<< FRAC_BITS;

  coord_t    mat [ENTRY_COUNT];
  logic      v_mul;
  logic      v_sum;
  pipe_ctl_t ctl;
  logic      accept;

  logic signed [ACC_W-1:0] acc_x;
  logic signed [ACC_W-1:0] acc_y;
  logic signed [ACC_W-1:0] acc_z;

  always_comb begin
    ctl.adv_out = !out_valid || !out_stall;
    ctl.adv_sum = !v_sum || ctl.adv_out;
    ctl.adv_mul = !v_mul || ctl.adv_sum;
    in_stall    = !ctl.adv_mul;
    accept      = in_valid && !in_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        mat[i] <= ((i == 0) || (i == 4) || (i == 8)) ? ONE : '0;
      end
    end else if (accept && opcode == OP_LOAD && entry_index < INDEX_W'(ENTRY_COUNT)) begin
      mat[entry_index] <= entry_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_mul     <= 1'b0;
      v_sum     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.adv_mul) begin
        v_mul <= accept && opcode == OP_XFORM;
      end
      if (ctl.adv_sum) begin
        v_sum <= v_mul;
      end
      if (ctl.adv_out) begin
        out_valid <= v_sum;
      end
    end
  end

  apt_lane #(.FRAC_BITS(FRAC_BITS), .ACC_W(ACC_W)) u_lane_x (
    .clk(clk), .ctl(ctl),
    .coef_x(mat[0]), .coef_y(mat[3]), .coef_z(mat[6]), .trans(mat[9]),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .acc(acc_x)
  );

  apt_lane #(.FRAC_BITS(FRAC_BITS), .ACC_W(ACC_W)) u_lane_y (
    .clk(clk), .ctl(ctl),
    .coef_x(mat[1]), .coef_y(mat[4]), .coef_z(mat[7]), .trans(mat[10]),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .acc(acc_y)
  );

  apt_lane #(.FRAC_BITS(FRAC_BITS), .ACC_W(ACC_W)) u_lane_z (
    .clk(clk), .ctl(ctl),
    .coef_x(mat[2]), .coef_y(mat[5]), .coef_z(mat[8]), .trans(mat[11]),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .acc(acc_z)
  );

  apt_merge #(.ACC_W(ACC_W)) u_merge (
    .clk(clk), .ctl(ctl),
    .acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z),
    .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .saturated(saturated)
  );

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    accept && opcode == OP_LOAD |=> !v_mul)
    else $error("load request entered the pipeline");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> v_mul && v_sum && out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  a_reset_identity: assert property (@(posedge clk)
    rst |=> mat[0] == ONE && mat[4] == ONE && mat[8] == ONE && mat[9] == '0)
    else $error("matrix not identity after reset");

  a_sat_clamped: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      out_x == {1'b0, {(COORD_W-1){1'b1}}} || out_x == {1'b1, {(COORD_W-1){1'b0}}} ||
      out_y == {1'b0, {(COORD_W-1){1'b1}}} || out_y == {1'b1, {(COORD_W-1){1'b0}}} ||
      out_z == {1'b0, {(COORD_W-1){1'b1}}} || out_z == {1'b1, {(COORD_W-1){1'b0}}})
    else $error("saturation flag without a clamped component");

endmodule
